FILE: hw/rtl/iprw_pkg.sv
// Shared types, constants and helpers for the IPv4 ID rewrite and checksum unit.
package iprw_pkg;

    localparam int ID_W              = 16;
    localparam int WORD_W            = 16;
    localparam int KEY_W             = 8;
    localparam int IDX_W             = 5;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 16;
    localparam int COUNTER_DEPTH_DEF = 256;
    localparam int MIN_IHL           = 5;

    localparam logic [ID_W-1:0] SEED_RESET = 16'hACE1;
    localparam logic [ID_W-1:0] STEP_RESET = 16'd1;
    localparam logic [ID_W-1:0] LFSR_TAPS  = 16'hB400;

    // Word positions inside the header that the checksum treats specially
    localparam logic [IDX_W-1:0] ID_WORD_POS   = 5'd2;
    localparam logic [IDX_W-1:0] CSUM_WORD_POS = 5'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ID_MODE     = 2'd0,
        REG_ID_STEP     = 2'd1,
        REG_RANDOM_SEED = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
    } id_upd_t;

    // Remainder of an 8-bit key by a fixed depth, by restoring subtraction
    function automatic logic [KEY_W-1:0] key_mod(input logic [KEY_W-1:0] key,
                                                  input int unsigned depth);
        logic [15:0] rem;
        logic [15:0] div;
        rem = {8'd0, key};
        for (int i = KEY_W - 1; i >= 0; i--)
        begin
            div = 16'(depth) << i;
            if (rem >= div)
            begin
                rem = rem - div;
            end
        end
        return rem[KEY_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/iprw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module iprw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/iprw_id_gen.sv
// Per-port ID counter table, pseudo-random generator and configuration registers.
module iprw_id_gen import iprw_pkg::*; #(
    parameter int COUNTER_DEPTH = COUNTER_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_wr_t          cfg,
    input  logic             req_valid,
    input  logic [KEY_W-1:0] req_key,
    output id_upd_t          upd
);

    localparam int SLOT_W = $clog2(COUNTER_DEPTH);

    logic [KEY_W-1:0]         key_rem;
    logic [SLOT_W-1:0]        req_slot;
    logic [ID_W-1:0]          rd_data;

    logic                     mode_reg;
    logic [ID_W-1:0]          step_reg;
    logic [ID_W-1:0]          lfsr_reg;
    logic [ID_W-1:0]          lfsr_next;
    logic [COUNTER_DEPTH-1:0] valid_reg;

    logic                     s1_valid_reg;
    logic [SLOT_W-1:0]        s1_slot_reg;
    logic                     s1_present_reg;

    logic                     wr_valid_reg;
    logic [SLOT_W-1:0]        wr_slot_reg;
    logic [ID_W-1:0]          wr_data_reg;

    logic [ID_W-1:0]          base;
    logic [ID_W-1:0]          new_id;

    assign key_rem  = key_mod(req_key, COUNTER_DEPTH);
    assign req_slot = key_rem[SLOT_W-1:0];

    iprw_ram #(
        .WIDTH (ID_W),
        .DEPTH (COUNTER_DEPTH)
    ) u_counter_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_slot_reg),
        .wdata (new_id),
        .re    (req_valid),
        .raddr (req_slot),
        .rdata (rd_data)
    );

    assign lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : '0);

    // Take the value written last cycle when it hit the same slot
    always_comb
    begin
        if (wr_valid_reg && (wr_slot_reg == s1_slot_reg))
        begin
            base = wr_data_reg;
        end
        else if (s1_present_reg)
        begin
            base = rd_data;
        end
        else
        begin
            base = '0;
        end
        new_id = mode_reg ? lfsr_next : ID_W'(base + step_reg);
    end

    assign upd.valid = s1_valid_reg;
    assign upd.id    = new_id;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            step_reg       <= STEP_RESET;
            lfsr_reg       <= SEED_RESET;
            valid_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            s1_slot_reg    <= '0;
            s1_present_reg <= 1'b0;
            wr_valid_reg   <= 1'b0;
            wr_slot_reg    <= '0;
            wr_data_reg    <= '0;
        end
        else
        begin
            s1_valid_reg   <= req_valid;
            s1_slot_reg    <= req_slot;
            s1_present_reg <= valid_reg[req_slot];
            wr_valid_reg   <= s1_valid_reg;
            wr_slot_reg    <= s1_slot_reg;
            wr_data_reg    <= new_id;

            if (s1_valid_reg)
            begin
                valid_reg[s1_slot_reg] <= 1'b1;
            end

            if (cfg.we)
            begin
                case (cfg.index)
                    REG_ID_MODE:
                    begin
                        mode_reg <= cfg.data[0];
                    end
                    REG_ID_STEP:
                    begin
                        step_reg <= cfg.data[ID_W-1:0];
                    end
                    REG_RANDOM_SEED:
                    begin
                        lfsr_reg <= (cfg.data[ID_W-1:0] != '0) ? cfg.data[ID_W-1:0]
                                                                : SEED_RESET;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (s1_valid_reg && mode_reg)
            begin
                lfsr_reg <= lfsr_next;
            end
        end
    end

endmodule

FILE: hw/rtl/iprw_csum.sv
// Header word tracking, ones-complement checksum and result register.
module iprw_csum import iprw_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_accept,
    input  logic [WORD_W-1:0] word,
    input  logic              first,
    input  id_upd_t           upd,
    input  logic              out_ready,
    output logic              in_ready,
    output logic              out_valid,
    output logic [ID_W-1:0]   out_id,
    output logic [ID_W-1:0]   out_checksum
);

    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  hw_reg;
    logic [WORD_W-1:0] sum_reg;
    logic [ID_W-1:0]   pending_reg;
    logic              out_valid_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [ID_W-1:0]   out_csum_reg;
    logic              skid_valid_reg;
    logic [ID_W-1:0]   skid_id_reg;
    logic [ID_W-1:0]   skid_csum_reg;

    logic              active;
    logic [IDX_W-1:0]  idx_eff;
    logic [IDX_W-1:0]  idx_inc;
    logic [IDX_W-1:0]  hw_eff;
    logic [3:0]        ihl;
    logic [WORD_W-1:0] used;
    logic [WORD_W-1:0] sum_base;
    logic [WORD_W:0]   sum_raw;
    logic [WORD_W-1:0] sum_fold;
    logic              done;
    logic              push;
    logic              out_load;

    always_comb
    begin
        active   = first || (idx_reg != '0);
        idx_eff  = first ? '0 : idx_reg;
        idx_inc  = IDX_W'(idx_eff + 1'b1);
        ihl      = (word[11:8] < 4'(MIN_IHL)) ? 4'(MIN_IHL) : word[11:8];
        hw_eff   = first ? {ihl, 1'b0} : hw_reg;
        sum_base = first ? '0 : sum_reg;

        if (idx_eff == ID_WORD_POS)
        begin
            used = pending_reg;
        end
        else if (idx_eff == CSUM_WORD_POS)
        begin
            used = '0;
        end
        else
        begin
            used = word;
        end

        sum_raw  = {1'b0, sum_base} + {1'b0, used};
        // end-around carry
        sum_fold = WORD_W'(sum_raw[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, sum_raw[WORD_W]});
        done     = (idx_inc >= hw_eff);
        push     = in_accept && active && done;
    end

    // Output register can take a new result when empty or being drained
    assign out_load     = !out_valid_reg || out_ready;
    assign in_ready     = !skid_valid_reg;
    assign out_valid    = out_valid_reg;
    assign out_id       = out_id_reg;
    assign out_checksum = out_csum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            hw_reg         <= IDX_W'(2 * MIN_IHL);
            sum_reg        <= '0;
            pending_reg    <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (upd.valid)
            begin
                pending_reg <= upd.id;
            end

            if (in_accept && active)
            begin
                sum_reg <= sum_fold;
                hw_reg  <= hw_eff;
                idx_reg <= done ? '0 : idx_inc;
            end

            if (out_load)
            begin
                out_valid_reg  <= skid_valid_reg || push;
                skid_valid_reg <= 1'b0;
            end
            else if (push)
            begin
                // park the result while the output waits
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (skid_valid_reg)
            begin
                out_id_reg   <= skid_id_reg;
                out_csum_reg <= skid_csum_reg;
            end
            else if (push)
            begin
                out_id_reg   <= pending_reg;
                out_csum_reg <= ~sum_fold;
            end
        end
        else if (push)
        begin
            skid_id_reg   <= pending_reg;
            skid_csum_reg <= ~sum_fold;
        end
    end

endmodule

FILE: hw/rtl/ipv4_id_rewrite_checksum_unit.sv
// Top level of the IPv4 identification rewrite and header checksum unit.
//
// Input stream: one 16-bit IPv4 header word per request, in header order.
// s_tuser marks the first word of a header; s_tdata carries the word and,
// on the first word, the egress port key that selects an ID counter.
// Output stream: one request per complete header (2*IHL words, IHL below 5
// counts as 5) holding the new identification and the new header checksum.
// Words before any first word are dropped; a first word mid-header restarts.
// Throughput: one header word per cycle while s_tready is high. The counter
// table is a RAM with registered read data; the updated ID is written back
// the cycle after the first word, with a one-entry bypass when headers hit
// the same slot. A finished result enters the output register when it is free.
// When the receiver stalls, the result is held in the output register and a
// second finished header parks in a spare register; s_tready drops only
// while the spare is full and rises the cycle after the output is taken.
// Reset clears all counters to zero (per-entry valid flags), loads the
// generator with its default seed and sets mode to pace with a step of one;
// no clearing pass is needed.
// Configuration: cfg_index 0 = mode, 1 = step, 2 = seed; write only idle.
module ipv4_id_rewrite_checksum_unit import iprw_pkg::*; #(
    parameter int COUNTER_DEPTH = COUNTER_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // header_word[15:0], port_key[23:16]
    input  logic                  s_tuser,   // first_word[0]

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // new_id[15:0], new_checksum[31:16]

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic      in_accept;
    cfg_wr_t   cfg;
    id_upd_t   upd;
    logic [ID_W-1:0] out_id;
    logic [ID_W-1:0] out_checksum;

    assign in_accept = s_tvalid && s_tready;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    iprw_id_gen #(
        .COUNTER_DEPTH (COUNTER_DEPTH)
    ) u_id_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (in_accept && s_tuser),
        .req_key   (s_tdata[23:16]),
        .upd       (upd)
    );

    iprw_csum u_csum (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_accept    (in_accept),
        .word         (s_tdata[15:0]),
        .first        (s_tuser),
        .upd          (upd),
        .out_ready    (m_tready),
        .in_ready     (s_tready),
        .out_valid    (m_tvalid),
        .out_id       (out_id),
        .out_checksum (out_checksum)
    );

    assign m_tdata = {out_checksum, out_id};

endmodule

FILE: dv/tb_ipv4_id_rewrite_checksum_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the IPv4 ID rewrite and header checksum unit.

typedef struct packed {
    logic [15:0] csum;
    logic [15:0] id;
} hdr_result_t;

class hdr_scoreboard;
    logic [15:0] id_ctr [iprw_pkg::COUNTER_DEPTH_DEF];
    logic [15:0] lfsr;
    logic [4:0]  word_pos;
    logic [4:0]  hdr_len;
    logic [16:0] csum_acc;
    logic [15:0] cur_id;
    logic        rand_mode;
    logic [15:0] id_incr;
    hdr_result_t expected_q[$];
    int          mismatches;

    function new();
        foreach (id_ctr[i])
        begin
            id_ctr[i] = '0;
        end
        lfsr       = iprw_pkg::SEED_RESET;
        word_pos   = '0;
        hdr_len    = 5'd10;
        csum_acc   = '0;
        cur_id     = '0;
        rand_mode  = 1'b0;
        id_incr    = iprw_pkg::STEP_RESET;
        mismatches = 0;
    endfunction

    function void apply_write(logic [iprw_pkg::CFG_IDX_W-1:0] idx,
                              logic [iprw_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            iprw_pkg::REG_ID_MODE:     rand_mode = data[0];
            iprw_pkg::REG_ID_STEP:     id_incr = data;
            iprw_pkg::REG_RANDOM_SEED: lfsr = (data != '0) ? data : iprw_pkg::SEED_RESET;
            default: ;
        endcase
    endfunction

    // Advance the header state by one accepted word; queue a result at header end
    function void note_request(logic [15:0] word, logic first, logic [7:0] key);
        logic [3:0]  ihl;
        int          slot;
        logic [15:0] term;
        logic [16:0] s;
        hdr_result_t r;
        if (first)
        begin
            ihl = word[11:8];
            if (ihl < iprw_pkg::MIN_IHL)
            begin
                ihl = 4'(iprw_pkg::MIN_IHL);
            end
            hdr_len = {ihl, 1'b0};
            slot = key % iprw_pkg::COUNTER_DEPTH_DEF;
            if (rand_mode)
            begin
                lfsr = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? iprw_pkg::LFSR_TAPS : 16'h0000);
                id_ctr[slot] = lfsr;
            end
            else
            begin
                id_ctr[slot] = id_ctr[slot] + id_incr;
            end
            cur_id   = id_ctr[slot];
            csum_acc = '0;
            word_pos = '0;
        end
        else if (word_pos == '0)
        begin
            return;
        end
        term = word;
        if (word_pos == iprw_pkg::ID_WORD_POS)
        begin
            term = cur_id;
        end
        else if (word_pos == iprw_pkg::CSUM_WORD_POS)
        begin
            term = '0;
        end
        // end-around carry keeps the sum folded to 16 bits
        s = {1'b0, csum_acc[15:0]} + {1'b0, term};
        if (s[16])
        begin
            s = {1'b0, s[15:0]} + 17'd1;
        end
        csum_acc = s;
        word_pos = word_pos + 5'd1;
        if (word_pos >= hdr_len)
        begin
            word_pos = '0;
            r.id   = cur_id;
            r.csum = ~csum_acc[15:0];
            expected_q.push_back(r);
        end
    endfunction

    function void check_result(logic [31:0] data);
        hdr_result_t got;
        hdr_result_t want;
        got = data;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            $display("%0t: result with none pending: expected none, actual %h", $time, data);
            return;
        end
        want = expected_q.pop_front();
        if (got.id !== want.id)
        begin
            mismatches++;
            $display("%0t: new_id mismatch: expected %h, actual %h", $time, want.id, got.id);
        end
        if (got.csum !== want.csum)
        begin
            mismatches++;
            $display("%0t: new_checksum mismatch: expected %h, actual %h",
                     $time, want.csum, got.csum);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_ipv4_id_rewrite_checksum_unit;
    import iprw_pkg::*;

    localparam int LIMIT       = 400000;
    localparam int ITEM_TARGET = 650;
    localparam int PHASE_ITEMS = 80;
    localparam int HOLD_CYCLES = 400;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit tx_idle;
    bit rx_idle;
    bit hold_request;
    int items_sent;

    hdr_scoreboard sb = new();

    ipv4_id_rewrite_checksum_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic push_word(input logic [15:0] word, input logic first,
                             input logic [7:0] key);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {key, word};
        s_tuser  <= first;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_request(word, first, key);
        items_sent++;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Send a header of the given IHL; cut drops its tail so the next header restarts
    task automatic send_header(input logic [3:0] ihl, input logic [7:0] key,
                               input bit cut, input bit all_ones);
        int          len;
        int          n;
        logic [15:0] w;
        len = (ihl < MIN_IHL) ? 2 * MIN_IHL : 2 * ihl;
        n = cut ? $urandom_range(1, len - 1) : len;
        for (int i = 0; i < n; i++)
        begin
            if (i == 0)
            begin
                w = {4'($urandom), ihl, 8'($urandom)};
            end
            else
            begin
                w = all_ones ? 16'hFFFF : 16'($urandom);
            end
            push_word(w, i == 0, (i == 0) ? key : 8'($urandom));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.apply_write(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and wait until every pending header result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int          pick;
        int          phase_end;
        logic [3:0]  ihl;
        logic [7:0]  key;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        rst_n        = 1'b0;
        tx_idle      = 1'b0;
        rx_idle      = 1'b1;
        hold_request = 1'b0;
        items_sent   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray word before any header
        push_word(16'hFFFF, 1'b0, 8'hFF);
        // IHL of zero counts as five
        push_word(16'h4000, 1'b1, 8'h00);
        push_word(16'hFFFF, 1'b0, 8'h00);
        push_word(16'h1234, 1'b0, 8'h00);
        push_word(16'h0000, 1'b0, 8'h00);
        push_word(16'hFFFF, 1'b0, 8'h00);
        push_word(16'hABCD, 1'b0, 8'h00);
        push_word(16'hFFFF, 1'b0, 8'h00);
        push_word(16'hFFFF, 1'b0, 8'h00);
        push_word(16'hFFFF, 1'b0, 8'h00);
        push_word(16'hFFFF, 1'b0, 8'h00);
        // restart mid-header on the same slot
        push_word(16'h4FFF, 1'b1, 8'hFF);
        push_word(16'h0000, 1'b0, 8'h00);
        push_word(16'h4500, 1'b1, 8'hFF);
        for (int i = 1; i < 10; i++)
        begin
            push_word(16'hFFFF, 1'b0, 8'hFF);
        end
        settle();

        for (int p = 0; items_sent < ITEM_TARGET; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(REG_ID_STEP, 16'h0000);
                    write_reg(REG_SPARE, 16'h5A5A);
                end
                1: write_reg(REG_ID_STEP, 16'hFFFF);
                2:
                begin
                    write_reg(REG_ID_MODE, 16'd1);
                    write_reg(REG_RANDOM_SEED, 16'h0000);
                end
                3: write_reg(REG_RANDOM_SEED, 16'h0001);
                4: write_reg(REG_RANDOM_SEED, 16'hFFFF);
                5:
                begin
                    write_reg(REG_ID_MODE, 16'd0);
                    write_reg(REG_ID_STEP, 16'd1);
                end
                default:
                begin
                    write_reg(REG_ID_MODE, 16'($urandom_range(0, 1)));
                    write_reg(REG_ID_STEP, 16'($urandom));
                    write_reg(REG_RANDOM_SEED, 16'($urandom));
                end
            endcase
            tx_idle = (p % 3) != 1;
            rx_idle = (p % 4) != 3;
            if (p == 1)
            begin
                // back up the output while the sender keeps pushing
                tx_idle      = 1'b0;
                hold_request = 1'b1;
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < ITEM_TARGET)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                begin
                    push_word(16'($urandom), 1'b0, 8'($urandom));
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: ihl = 4'd5;
                        6:                ihl = 4'($urandom_range(6, 8));
                        7:                ihl = 4'($urandom_range(9, 15));
                        default:          ihl = 4'($urandom_range(0, 4));
                    endcase
                    // hot slots exercise back-to-back updates of one counter
                    key = ($urandom_range(0, 9) < 4) ? 8'($urandom_range(0, 3))
                                                     : 8'($urandom);
                    send_header(ihl, key, pick < 12, pick >= 95);
                end
            end
            settle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        int   stall_left;
        int   hold_left;
        logic rdy;
        stall_left = 0;
        hold_left  = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                sb.check_result(m_tdata);
                stall_left = rx_idle ? $urandom_range(0, 15) : 0;
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: ipv4_id_rewrite_checksum_unit.f
hw/rtl/iprw_pkg.sv
hw/rtl/iprw_ram.sv
hw/rtl/iprw_id_gen.sv
hw/rtl/iprw_csum.sv
hw/rtl/ipv4_id_rewrite_checksum_unit.sv
dv/tb_ipv4_id_rewrite_checksum_unit.sv
